// ===== rtl/button_set_countdown_timer_assert.svh =====
// Assertion macros for the countdown timer.
// Used by the top level only; needs no package.
`ifndef BUTTON_SET_COUNTDOWN_TIMER_ASSERT_SVH
`define BUTTON_SET_COUNTDOWN_TIMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSCT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bsct_pkg.sv =====
// Shared constants, widths and control structs for the countdown timer.
// No dependencies.
`timescale 1ns / 1ps

package bsct_pkg;

    parameter int MAX_MINUTES        = 99;
    parameter int SECONDS_PER_MINUTE = 60;
    parameter int BAR_WIDTH          = 14;
    parameter int PERCENT_SCALE      = 100;

    parameter int MIN_W   = 7;
    parameter int SEC_W   = 13;
    parameter int PCT_W   = 7;
    parameter int BAR_W   = 4;
    parameter int SERVO_W = 11;
    parameter int NUM_W   = 20;

    parameter int S_TDATA_W = 8;
    parameter int M_TDATA_W = 48;

    parameter logic [SERVO_W-1:0] PULSE_REST = 11'd1000;
    parameter logic [SERVO_W-1:0] PULSE_RUN  = 11'd1500;

    // Quotient is at most PERCENT_SCALE, so seven restoring steps suffice.
    parameter int DIV_STEPS = 7;
    parameter int CNT_W     = 3;

    // bar = percent * BAR_WIDTH / 100, done as a reciprocal multiply.
    parameter int BAR_MULT  = BAR_WIDTH * 1311;
    parameter int BAR_SHIFT = 17;
    parameter int BAR_PROD_W = 22;

    typedef struct packed {
        logic accept;
        logic mul_load;
        logic div_step;
        logic bar_load;
        logic out_load;
    } bsct_cmd_t;

    typedef struct packed {
        logic out_free;
    } bsct_status_t;

endpackage

// ===== rtl/button_set_countdown_timer.sv =====
// Channel  | Dir | Signals                    | Beat contents
// s_axis   | in  | s_tvalid s_tready s_tdata  | one poll period of button samples and tick
// m_axis   | out | m_tvalid m_tready m_tdata  | timer state after that poll period
//
// Each input beat passes through these steps in order: accepting it and updating the timer
// state, the multiplies, the restoring percent divider, the bar scaling and the load of the
// output register. A result waiting in the output register stalls only the final load;
// the next input is taken once it is loaded. rst_n clears the timer state with the servo
// pulse at rest.
//
// Top level of the countdown timer; depends on bsct_pkg, bsct_ctrl, bsct_datapath and
// button_set_countdown_timer_assert.svh.
`timescale 1ns / 1ps

`include "button_set_countdown_timer_assert.svh"

module button_set_countdown_timer
    import bsct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] start_first, [1] start_second, [2] raise_first, [3] raise_second,
    // [4] lower_first, [5] lower_second, [6] second_tick, [7] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] running, [7:1] minutes_set, [20:8] seconds_left, [27:21] percent_left,
    // [31:28] bar_cells, [42:32] servo_pulse_us, [43] timer_done, [47:44] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    bsct_cmd_t    cmd;
    bsct_status_t status;

    bsct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bsct_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `BSCT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken while busy")
    `BSCT_ASSERT_SAME(a_done_rest, clk, rst_n, m_tvalid && m_tdata[43], !m_tdata[0] && (m_tdata[42:32] == PULSE_REST), "done without rest pulse")
    `BSCT_ASSERT_SAME(a_run_pulse, clk, rst_n, m_tvalid && m_tdata[0], m_tdata[42:32] == PULSE_RUN, "running without run pulse")
    `BSCT_ASSERT_SAME(a_pct_range, clk, rst_n, m_tvalid, m_tdata[27:21] <= PCT_W'(PERCENT_SCALE), "percent above full scale")

endmodule

// ===== rtl/bsct_ctrl.sv =====
// Sequencer for the countdown timer: accept, multiply, divide, bar, output.
// Depends on bsct_pkg.
`timescale 1ns / 1ps

module bsct_ctrl
    import bsct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  bsct_status_t status,
    output bsct_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_BAR,
        ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    state_next = ST_MUL;
                    ready_next = 1'b0;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_BAR;
                end
            end
            ST_BAR:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready     = ready_reg;
    assign cmd.accept   = s_tvalid && ready_reg;
    assign cmd.mul_load = (state_reg == ST_MUL);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.bar_load = (state_reg == ST_BAR);
    assign cmd.out_load = (state_reg == ST_OUT) && status.out_free;

endmodule

// ===== rtl/bsct_datapath.sv =====
// Timer state, button edge logic, percent divider, bar scaling and output register.
// Depends on bsct_pkg; driven by bsct_ctrl.
`timescale 1ns / 1ps

module bsct_datapath
    import bsct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  bsct_cmd_t            cmd,
    output bsct_status_t         status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Timer state.
    logic [MIN_W-1:0]   minutes_reg, minutes_next;
    logic               running_reg, running_next;
    logic [SEC_W-1:0]   seconds_reg, seconds_next;
    logic [SERVO_W-1:0] servo_reg, servo_next;
    logic               done_reg, done_next;
    logic               prev_start_reg, prev_raise_reg, prev_lower_reg;

    // Divider and scaling.
    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   den_sh_reg;
    logic [SEC_W-1:0]   den_reg;
    logic [PCT_W-1:0]   quot_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [BAR_W-1:0]   bar_reg;
    logic [SEC_W-1:0]   den_next;
    logic [PCT_W-1:0]   pct_next;
    logic [BAR_PROD_W-1:0] bar_prod;

    // Output register.
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic lv_start, lv_raise, lv_lower, tick;
    logic [MIN_W-1:0] min_up;
    logic [SEC_W-1:0] sec_dec;

    // A button reads pressed only when both samples are low.
    assign lv_start = s_tdata[0] | s_tdata[1];
    assign lv_raise = s_tdata[2] | s_tdata[3];
    assign lv_lower = s_tdata[4] | s_tdata[5];
    assign tick     = s_tdata[6];

    always_comb
    begin
        min_up       = minutes_reg;
        minutes_next = minutes_reg;
        running_next = running_reg;
        seconds_next = seconds_reg;
        servo_next   = servo_reg;
        done_next    = 1'b0;
        sec_dec      = seconds_reg;

        if (!running_reg)
        begin
            if (!lv_raise && prev_raise_reg && (minutes_reg < MIN_W'(MAX_MINUTES)))
            begin
                min_up = minutes_reg + 1'b1;
            end
            minutes_next = min_up;
            if (!lv_lower && prev_lower_reg && (min_up != '0))
            begin
                minutes_next = min_up - 1'b1;
            end
            if (!lv_start && prev_start_reg && (minutes_next != '0))
            begin
                servo_next   = PULSE_RUN;
                seconds_next = SEC_W'(minutes_next) * SEC_W'(SECONDS_PER_MINUTE);
                running_next = 1'b1;
            end
        end
        else if (tick)
        begin
            // Start is ignored while running, so only an already running timer counts.
            if (seconds_reg != '0)
            begin
                sec_dec = seconds_reg - 1'b1;
            end
            seconds_next = sec_dec;
            if (sec_dec == '0)
            begin
                done_next    = 1'b1;
                running_next = 1'b0;
                minutes_next = '0;
                servo_next   = PULSE_REST;
            end
        end

        if (!running_next)
        begin
            seconds_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minutes_reg    <= '0;
            running_reg    <= 1'b0;
            seconds_reg    <= '0;
            servo_reg      <= PULSE_REST;
            done_reg       <= 1'b0;
            prev_start_reg <= 1'b1;
            prev_raise_reg <= 1'b1;
            prev_lower_reg <= 1'b1;
        end
        else if (cmd.accept)
        begin
            minutes_reg    <= minutes_next;
            running_reg    <= running_next;
            seconds_reg    <= seconds_next;
            servo_reg      <= servo_next;
            done_reg       <= done_next;
            prev_start_reg <= lv_start;
            prev_raise_reg <= lv_raise;
            prev_lower_reg <= lv_lower;
        end
    end

    assign den_next = SEC_W'(minutes_reg) * SEC_W'(SECONDS_PER_MINUTE);

    // Percent is zero when idle or when the total is zero.
    assign pct_next = (running_reg && (den_reg != '0)) ? quot_reg : '0;
    assign bar_prod = BAR_PROD_W'(pct_next) * BAR_PROD_W'(BAR_MULT);

    // Restoring division of seconds * 100 by the total, one quotient bit per step.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            rem_reg    <= NUM_W'(seconds_reg) * NUM_W'(PERCENT_SCALE);
            den_reg    <= den_next;
            den_sh_reg <= NUM_W'(den_next) << (DIV_STEPS - 1);
            quot_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= den_sh_reg)
            begin
                rem_reg  <= rem_reg - den_sh_reg;
                quot_reg <= {quot_reg[PCT_W-2:0], 1'b1};
            end
            else
            begin
                quot_reg <= {quot_reg[PCT_W-2:0], 1'b0};
            end
            den_sh_reg <= den_sh_reg >> 1;
        end

        if (cmd.bar_load)
        begin
            pct_reg <= pct_next;
            bar_reg <= bar_prod[BAR_SHIFT +: BAR_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {4'b0000, done_reg, servo_reg, bar_reg, pct_reg,
                             seconds_reg, minutes_reg, running_reg};
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

endmodule
